// File: sv/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, codes and the power-up phase table of the 4-bit character
// LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

   localparam logic [2:0] OP_INIT      = 3'd0;
   localparam logic [2:0] OP_WRITE_CMD = 3'd1;
   localparam logic [2:0] OP_WRITE_DAT = 3'd2;
   localparam logic [2:0] OP_SET_POS   = 3'd3;
   localparam logic [2:0] OP_CLEAR     = 3'd4;

   localparam logic [7:0] CLEAR_CMD = 8'h01;

   localparam logic [12:0] HOLD_SHORT      = 13'd1;
   localparam logic [12:0] HOLD_CMD_TAIL   = 13'd5;
   localparam logic [12:0] HOLD_CLEAR_TAIL = 13'd305;

   localparam logic [5:0] INIT_LAST_PHASE = 6'd33;
   localparam logic [2:0] BYTE_LAST_STEP  = 3'd4;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] byte_value;
      logic [5:0] column;
      logic       row;
   } req_type;

   typedef struct packed {
      logic        rs_level;
      logic        enable_level;
      logic [3:0]  data_nibble;
      logic [12:0] hold_time;
      logic        last_phase;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_INIT = 2'd0,
      JOB_CMD  = 2'd1,
      JOB_DATA = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   cmd_byte;
      logic         clear_tail;
   } job_type;

   function automatic rsp_type make_phase(input logic en, input logic [3:0] nib,
                                          input logic [12:0] hold);
      rsp_type p;
      p.rs_level     = 1'b0;
      p.enable_level = en;
      p.data_nibble  = nib;
      p.hold_time    = hold;
      p.last_phase   = 1'b0;
      return p;
   endfunction

   // Power-up sequence: reset nibbles, then commands 0x28, 0x08, 0x01, 0x06, 0x0C.
   function automatic rsp_type init_phase(input logic [5:0] idx);
      rsp_type p;
      unique case (idx)
         6'd0:  p = make_phase(1'b0, 4'h0, 13'd4500);
         6'd1:  p = make_phase(1'b1, 4'h3, 13'd1);
         6'd2:  p = make_phase(1'b0, 4'h3, 13'd500);
         6'd3:  p = make_phase(1'b1, 4'h3, 13'd1);
         6'd4:  p = make_phase(1'b0, 4'h3, 13'd500);
         6'd5:  p = make_phase(1'b1, 4'h3, 13'd1);
         6'd6:  p = make_phase(1'b0, 4'h3, 13'd500);
         6'd7:  p = make_phase(1'b1, 4'h2, 13'd1);
         6'd8:  p = make_phase(1'b0, 4'h2, 13'd100);
         6'd9:  p = make_phase(1'b0, 4'h2, 13'd1);
         6'd10: p = make_phase(1'b1, 4'h2, 13'd1);
         6'd11: p = make_phase(1'b0, 4'h2, 13'd1);
         6'd12: p = make_phase(1'b1, 4'h8, 13'd1);
         6'd13: p = make_phase(1'b0, 4'h8, 13'd5);
         6'd14: p = make_phase(1'b0, 4'h8, 13'd1);
         6'd15: p = make_phase(1'b1, 4'h0, 13'd1);
         6'd16: p = make_phase(1'b0, 4'h0, 13'd1);
         6'd17: p = make_phase(1'b1, 4'h8, 13'd1);
         6'd18: p = make_phase(1'b0, 4'h8, 13'd5);
         6'd19: p = make_phase(1'b0, 4'h8, 13'd1);
         6'd20: p = make_phase(1'b1, 4'h0, 13'd1);
         6'd21: p = make_phase(1'b0, 4'h0, 13'd1);
         6'd22: p = make_phase(1'b1, 4'h1, 13'd1);
         6'd23: p = make_phase(1'b0, 4'h1, 13'd205);
         6'd24: p = make_phase(1'b0, 4'h1, 13'd1);
         6'd25: p = make_phase(1'b1, 4'h0, 13'd1);
         6'd26: p = make_phase(1'b0, 4'h0, 13'd1);
         6'd27: p = make_phase(1'b1, 4'h6, 13'd1);
         6'd28: p = make_phase(1'b0, 4'h6, 13'd5);
         6'd29: p = make_phase(1'b0, 4'h6, 13'd1);
         6'd30: p = make_phase(1'b1, 4'h0, 13'd1);
         6'd31: p = make_phase(1'b0, 4'h0, 13'd1);
         6'd32: p = make_phase(1'b1, 4'hC, 13'd1);
         6'd33: p = make_phase(1'b0, 4'hC, 13'd4505);
         default: p = make_phase(1'b0, 4'h0, 13'd4500);
      endcase
      return p;
   endfunction

endpackage

// File: sv/lcdseq_front.sv
// ----------------------------------------------------------------------------
// lcdseq_front
// Decodes an incoming request into a job for the phase sequencer.
// ----------------------------------------------------------------------------
module lcdseq_front
   import lcdseq_pkg::*;
(
   input  logic    req_valid,
   input  req_type req,
   output logic    req_stall,
   input  logic    queue_full,
   output logic    job_push,
   output job_type job
);

   logic accept;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;

   always_comb begin
      job.kind       = JOB_CMD;
      job.cmd_byte   = req.byte_value;
      job.clear_tail = 1'b0;
      job_push       = accept;
      unique case (req.operation)
         OP_INIT: begin
            job.kind = JOB_INIT;
         end
         OP_WRITE_CMD: begin
            job.kind = JOB_CMD;
         end
         OP_WRITE_DAT: begin
            job.kind = JOB_DATA;
         end
         OP_SET_POS: begin
            job.cmd_byte = {1'b1, req.row, req.column};
         end
         OP_CLEAR: begin
            job.cmd_byte   = CLEAR_CMD;
            job.clear_tail = 1'b1;
         end
         default: begin
            // Unused operation codes are taken and dropped.
            job_push = 1'b0;
         end
      endcase
   end

endmodule

// File: sv/lcdseq_queue.sv
// ----------------------------------------------------------------------------
// lcdseq_queue
// Two-entry job queue between the request decoder and the phase sequencer.
// ----------------------------------------------------------------------------
module lcdseq_queue
   import lcdseq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type    entries_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("job popped from an empty queue");

endmodule

// File: sv/lcdseq_back.sv
// ----------------------------------------------------------------------------
// lcdseq_back
// Phase sequencer: expands the job at the queue head into pin phases, one
// per cycle unless rsp_stall holds them, into a registered result stage.
// ----------------------------------------------------------------------------
module lcdseq_back
   import lcdseq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   output logic    rsp_valid,
   output rsp_type rsp,
   input  logic    rsp_stall
);

   logic [5:0] phase_ff;
   logic [5:0] phase_in;
   logic [3:0] held_nibble_ff;
   logic [3:0] held_nibble_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   rsp_type    cur;
   logic [2:0] step;
   logic [3:0] byte_nib;
   logic       advance;
   logic       fire;

   assign advance = ~rsp_valid_ff | ~rsp_stall;
   assign fire    = job_valid & advance;
   assign step    = (job.kind == JOB_DATA) ? phase_ff[2:0] + 3'd1 : phase_ff[2:0];
   assign byte_nib = (step < 3'd3) ? job.cmd_byte[7:4] : job.cmd_byte[3:0];

   always_comb begin
      if (job.kind == JOB_INIT) begin
         cur            = init_phase(phase_ff);
         cur.last_phase = phase_ff == INIT_LAST_PHASE;
      end else begin
         cur.rs_level     = job.kind == JOB_DATA;
         cur.enable_level = step[0];
         cur.data_nibble  = (step == 3'd0) ? held_nibble_ff : byte_nib;
         cur.hold_time    = HOLD_SHORT;
         cur.last_phase   = step == BYTE_LAST_STEP;
         if (step == BYTE_LAST_STEP) begin
            cur.hold_time = job.clear_tail ? HOLD_CLEAR_TAIL : HOLD_CMD_TAIL;
         end
      end
   end

   always_comb begin
      job_pop        = fire & cur.last_phase;
      rsp_valid_in   = fire | (rsp_valid_ff & rsp_stall);
      rsp_in         = fire ? cur : rsp_ff;
      held_nibble_in = fire ? cur.data_nibble : held_nibble_ff;
      phase_in       = phase_ff;
      if (fire) begin
         phase_in = cur.last_phase ? 6'd0 : phase_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= 6'd0;
         held_nibble_ff <= 4'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         held_nibble_ff <= held_nibble_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= INIT_LAST_PHASE)
      else $error("phase counter out of range");

   a_lead_in: assert property (@(posedge clock) disable iff (reset)
      (fire && job.kind == JOB_CMD && phase_ff == 6'd0) |=>
      (!rsp_ff.enable_level && rsp_ff.data_nibble == $past(held_nibble_ff)))
      else $error("command lead-in phase does not keep the held nibble");

   a_phase_restart: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> phase_ff == 6'd0)
      else $error("phase counter not restarted after a finished job");

endmodule

// File: sv/char_lcd_nibble_write_sequencer_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_unit
// Expands LCD requests (init, command, data, set position, clear) into pin
// phases for a 4-bit character display.
//
// The req channel takes one request per item. Each request produces a run of
// rsp items, one per pin phase, giving RS, E, the D4..D7 nibble and the hold
// time in 10 us units; the final phase of a run has last_phase set. Unused
// operation codes are accepted and produce nothing.
// A command, set position or clear takes 5 phases, a data write 4 and init 34.
// The phase sequencer emits one phase per cycle while rsp_stall does not
// hold it, and runs follow each other without gaps while jobs are queued.
// The first phase of a request is held in the job queue and then in the
// registered result stage before it is presented on rsp. A two-entry job
// queue lets new requests be accepted while a run is in progress; req_stall
// rises only when the queue is full. When rsp_stall is high, the presented
// phase holds and sequencing pauses. Reset empties the queue, drops any
// pending phase and sets the held nibble to zero.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_unit
   import lcdseq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp,
   input  logic    rsp_stall
);

   logic    queue_full;
   logic    job_push;
   job_type push_job;
   logic    job_pop;
   logic    head_valid;
   job_type head_job;

   lcdseq_front u_front (
      .req_valid  (req_valid),
      .req        (req),
      .req_stall  (req_stall),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job        (push_job)
   );

   lcdseq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   lcdseq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

endmodule

// File: tb/tb_char_lcd_nibble_write_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_write_sequencer_unit
// Self-checking bench for the 4-bit character LCD write sequencer. Requests
// are queued up front and sent by a clocked driver with random gaps. Each
// accepted request is expanded here into its expected pin phases. A clocked
// monitor applies random stalls and compares every phase with the oldest
// expected one. The run starts with a directed set of requests and continues
// with random ones.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_write_sequencer_unit;
   import lcdseq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 10;
   localparam int RANDOM_ITEMS   = 440;
   localparam int TAIL_CYCLES    = 50;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [2:0] OP_SPARE_A = 3'd5;
   localparam logic [2:0] OP_SPARE_B = 3'd6;
   localparam logic [2:0] OP_SPARE_C = 3'd7;

   localparam logic [7:0] FUNCTION_SET_CMD = 8'h28;
   localparam logic [7:0] DISPLAY_OFF_CMD  = 8'h08;
   localparam logic [7:0] ENTRY_MODE_CMD   = 8'h06;
   localparam logic [7:0] DISPLAY_ON_CMD   = 8'h0C;
   localparam logic [7:0] SET_POS_CMD      = 8'h80;

   localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
   localparam logic [3:0] FOUR_BIT_NIB  = 4'h2;
   localparam logic [12:0] POWER_UP_HOLD  = 13'd4500;
   localparam logic [12:0] WAKE_HOLD      = 13'd500;
   localparam logic [12:0] FOUR_BIT_HOLD  = 13'd100;
   localparam logic [12:0] INIT_CLEAR_ADD = 13'd200;
   localparam logic [12:0] CLEAR_ADD      = 13'd300;
   localparam logic [12:0] DISPLAY_ON_ADD = 13'd4500;

   typedef struct packed {
      req_type item;
      logic    wait_idle;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   req_type req = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp;
   logic    rsp_stall = 1'b0;

   pending_type pending_q[$];
   rsp_type     phase_q[$];
   logic [3:0]  held_nib = 4'h0;

   int idle_pct = 25;
   int send_gap = 0;
   int stall_left = 0;
   int req_taken_count = 0;
   int rsp_seen_count = 0;
   int fail_count = 0;
   int quiet_cycles = 0;

   char_lcd_nibble_write_sequencer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int pick_gap();
      if (idle_pct == 0 || $urandom_range(0, 99) >= idle_pct) begin
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic string phase_text(rsp_type p);
      return $sformatf("rs=%0d en=%0d nib=%h hold=%0d last=%0d", p.rs_level,
                       p.enable_level, p.data_nibble, p.hold_time, p.last_phase);
   endfunction

   function automatic void add_phase(logic rs, logic en, logic [3:0] nib,
                                     logic [12:0] hold);
      rsp_type p;
      p.rs_level     = rs;
      p.enable_level = en;
      p.data_nibble  = nib;
      p.hold_time    = hold;
      p.last_phase   = 1'b0;
      phase_q.push_back(p);
      held_nib = nib;
   endfunction

   function automatic void add_pulse(logic rs, logic [3:0] nib, logic [12:0] low_hold);
      add_phase(rs, 1'b1, nib, HOLD_SHORT);
      add_phase(rs, 1'b0, nib, low_hold);
   endfunction

   function automatic void add_byte(logic rs, logic [7:0] value, logic [12:0] extra);
      if (!rs) begin
         add_phase(1'b0, 1'b0, held_nib, HOLD_SHORT);
      end
      add_pulse(rs, value[7:4], HOLD_SHORT);
      add_pulse(rs, value[3:0], HOLD_CMD_TAIL + extra);
   endfunction

   function automatic void predict_phases(req_type r);
      int start;
      rsp_type tail;
      start = phase_q.size();
      case (r.operation)
         OP_INIT: begin
            add_phase(1'b0, 1'b0, 4'h0, POWER_UP_HOLD);
            repeat (3) add_pulse(1'b0, WAKE_NIBBLE, WAKE_HOLD);
            add_pulse(1'b0, FOUR_BIT_NIB, FOUR_BIT_HOLD);
            add_byte(1'b0, FUNCTION_SET_CMD, 13'd0);
            add_byte(1'b0, DISPLAY_OFF_CMD, 13'd0);
            add_byte(1'b0, CLEAR_CMD, INIT_CLEAR_ADD);
            add_byte(1'b0, ENTRY_MODE_CMD, 13'd0);
            add_byte(1'b0, DISPLAY_ON_CMD, DISPLAY_ON_ADD);
         end
         OP_WRITE_CMD: add_byte(1'b0, r.byte_value, 13'd0);
         OP_WRITE_DAT: add_byte(1'b1, r.byte_value, 13'd0);
         OP_SET_POS:   add_byte(1'b0, SET_POS_CMD | {1'b0, r.row, r.column}, 13'd0);
         OP_CLEAR:     add_byte(1'b0, CLEAR_CMD, CLEAR_ADD);
         default: ;
      endcase
      if (phase_q.size() > start) begin
         tail = phase_q.pop_back();
         tail.last_phase = 1'b1;
         phase_q.push_back(tail);
      end
   endfunction

   function automatic void queue_request(logic [2:0] op, logic [7:0] value,
                                         logic [5:0] col, logic row_sel, logic wait_idle);
      pending_type p;
      p.item.operation  = op;
      p.item.byte_value = value;
      p.item.column     = col;
      p.item.row        = row_sel;
      p.wait_idle       = wait_idle;
      pending_q.push_back(p);
   endfunction

   always @(posedge clock) begin
      logic free;
      pending_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         free = !req_valid;
         if (req_valid && !req_stall) begin
            predict_phases(req);
            req_taken_count++;
            free = 1'b1;
         end
         if (free) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0 &&
                         !(pending_q[0].wait_idle && phase_q.size() != 0)) begin
               nxt = pending_q.pop_front();
               req_valid <= 1'b1;
               req <= nxt.item;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen_count++;
            if (phase_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("result %0d arrived with nothing expected: %s",
                           rsp_seen_count, phase_text(rsp));
               end
            end else begin
               want = phase_q.pop_front();
               if (rsp.rs_level !== want.rs_level ||
                   rsp.enable_level !== want.enable_level ||
                   rsp.data_nibble !== want.data_nibble ||
                   rsp.hold_time !== want.hold_time ||
                   rsp.last_phase !== want.last_phase) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("result %0d mismatch: expected %s, got %s",
                              rsp_seen_count, phase_text(want), phase_text(rsp));
                  end
               end
            end
         end
         if (stall_left == 0) begin
            stall_left = pick_gap();
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) begin
            stall_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("CHECKS FAILED");
               $finish;
            end
         end
      end
   end

   initial begin
      int made;
      logic [2:0] op;
      int pick;

      queue_request(OP_INIT, 8'h00, 6'd0, 1'b0, 1'b0);
      queue_request(OP_WRITE_CMD, 8'h00, 6'd0, 1'b0, 1'b0);
      queue_request(OP_WRITE_CMD, 8'hFF, 6'd63, 1'b1, 1'b0);
      queue_request(OP_WRITE_DAT, 8'h00, 6'd63, 1'b1, 1'b0);
      queue_request(OP_WRITE_DAT, 8'hFF, 6'd0, 1'b0, 1'b0);
      queue_request(OP_WRITE_CMD, 8'hA5, 6'd21, 1'b0, 1'b0);
      queue_request(OP_WRITE_DAT, 8'h5A, 6'd42, 1'b1, 1'b0);
      queue_request(OP_SET_POS, 8'hFF, 6'd0, 1'b0, 1'b0);
      queue_request(OP_SET_POS, 8'h00, 6'd63, 1'b1, 1'b0);
      queue_request(OP_SET_POS, 8'h00, 6'd63, 1'b0, 1'b0);
      queue_request(OP_SET_POS, 8'hFF, 6'd0, 1'b1, 1'b0);
      queue_request(OP_CLEAR, 8'hFF, 6'd63, 1'b1, 1'b0);
      queue_request(OP_SPARE_A, 8'hFF, 6'd63, 1'b1, 1'b0);
      queue_request(OP_SPARE_B, 8'h00, 6'd0, 1'b0, 1'b0);
      queue_request(OP_SPARE_C, 8'hFF, 6'd63, 1'b1, 1'b0);
      queue_request(OP_WRITE_DAT, 8'h3C, 6'd0, 1'b0, 1'b0);
      queue_request(OP_INIT, 8'hFF, 6'd63, 1'b1, 1'b1);
      queue_request(OP_WRITE_DAT, 8'hC3, 6'd0, 1'b0, 1'b0);
      queue_request(OP_CLEAR, 8'h00, 6'd0, 1'b0, 1'b1);
      queue_request(OP_WRITE_CMD, 8'h01, 6'd0, 1'b0, 1'b0);

      made = 0;
      while (made < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            op = OP_INIT;
         end else if (pick < 28) begin
            op = OP_WRITE_CMD;
         end else if (pick < 55) begin
            op = OP_WRITE_DAT;
         end else if (pick < 75) begin
            op = OP_SET_POS;
         end else if (pick < 90) begin
            op = OP_CLEAR;
         end else begin
            op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
         end
         made++;
         queue_request(op, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                       1'($urandom_range(0, 1)), $urandom_range(0, 49) == 0);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (req_taken_count < 150) @(posedge clock);
      idle_pct = 0;
      while (req_taken_count < 230) @(posedge clock);
      idle_pct = 45;
      while (req_taken_count < 350) @(posedge clock);
      idle_pct = 12;

      while (pending_q.size() != 0 || req_valid || phase_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/lcdseq_pkg.sv
sv/lcdseq_front.sv
sv/lcdseq_queue.sv
sv/lcdseq_back.sv
sv/char_lcd_nibble_write_sequencer_unit.sv
tb/tb_char_lcd_nibble_write_sequencer_unit.sv
